>>> hdl/ray_convex_planes_clip_assert.svh
// ----------------------------------------------------------------------------
// Ray convex clip assertion macros
// Shared property forms for the clipper's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef RAY_CONVEX_PLANES_CLIP_ASSERT_SVH
`define RAY_CONVEX_PLANES_CLIP_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define RCPC_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is held
`define RCPC_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/rcpc_pkg.sv
// ----------------------------------------------------------------------------
// Ray convex clip package
// Payload types, control structs, state encoding and fixed-point constants.
// ----------------------------------------------------------------------------
`default_nettype none

package rcpc_pkg;

  localparam int FIELD_W = 32;                  // Q16.16 field width
  localparam int FRAC_W  = 16;                  // fraction bits
  localparam int EPS_W   = 16;                  // tolerance register width
  localparam int DIG_W   = 4;                   // multiplier digit
  localparam int DIGITS  = FIELD_W / DIG_W;     // digits per operand
  localparam int PROD_W  = 2 * FIELD_W - FRAC_W + 1;  // floored product
  localparam int DOT_W   = PROD_W + 1;          // three-term sum
  localparam int MAG_W   = DOT_W - 2;           // magnitude of a sum
  localparam int QUO_W   = FIELD_W - 1;         // unsaturated quotient bits
  localparam int OVF_SH  = QUO_W - FRAC_W;      // integer bits of quotient

  localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1);

  localparam logic signed [FIELD_W-1:0] Q_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
  localparam logic signed [FIELD_W-1:0] Q_MIN = {1'b1, {(FIELD_W-1){1'b0}}};

  typedef struct packed {
    logic signed [FIELD_W-1:0] dir_x;
    logic signed [FIELD_W-1:0] dir_y;
    logic signed [FIELD_W-1:0] dir_z;
    logic signed [FIELD_W-1:0] org_x;
    logic signed [FIELD_W-1:0] org_y;
    logic signed [FIELD_W-1:0] org_z;
    logic signed [FIELD_W-1:0] norm_x;
    logic signed [FIELD_W-1:0] norm_y;
    logic signed [FIELD_W-1:0] norm_z;
    logic signed [FIELD_W-1:0] plane_offset;
    logic                      last_plane;
  } rcpc_in_t;

  typedef struct packed {
    logic                      hit;
    logic signed [FIELD_W-1:0] t_near;
    logic signed [FIELD_W-1:0] t_far;
  } rcpc_out_t;

  typedef struct packed {
    logic load;    // capture operands, clear accumulator
    logic shift;   // consume one digit of the multiplier
    logic top;     // current digit is the signed top digit
  } rcpc_mul_ctl_t;

  typedef struct packed {
    logic done;    // last quotient bit is being formed
    logic ovf;     // quotient exceeds the Q16.16 range
  } rcpc_div_sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_EVAL,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_UPDATE,
    ST_EMIT
  } rcpc_state_t;

endpackage

`default_nettype wire

>>> hdl/rcpc_dig_mul.sv
// ----------------------------------------------------------------------------
// Digit-serial signed multiplier
// Multiplies two signed Q16.16 values one 4-bit multiplier digit per cycle
// with shift set, least significant digit first, and floors the product to Q16.16.
// ----------------------------------------------------------------------------
`default_nettype none

module rcpc_dig_mul (
  input  logic                                   clk,
  input  rcpc_pkg::rcpc_mul_ctl_t                ctl,
  input  logic signed [rcpc_pkg::FIELD_W-1:0]    mcand,
  input  logic signed [rcpc_pkg::FIELD_W-1:0]    mplier,
  output logic signed [rcpc_pkg::PROD_W-1:0]     prod
);

  import rcpc_pkg::*;

  localparam int PP_W  = FIELD_W + DIG_W + 1;
  localparam int ACC_W = PP_W + 1;
  localparam int HI_W  = ACC_W - DIG_W;

  logic signed [FIELD_W-1:0] a_r;
  logic        [FIELD_W-1:0] b_r;
  logic signed [HI_W-1:0]    hi_r;
  logic        [FIELD_W-1:0] lo_r;

  logic        [DIG_W-1:0]   dig;
  logic signed [DIG_W:0]     factor;
  logic signed [PP_W-1:0]    pp;
  logic signed [ACC_W-1:0]   acc;

  always_comb begin
    dig    = b_r[DIG_W-1:0];
    // top digit carries the two's complement weight
    factor = ctl.top ? {dig[DIG_W-1], dig} : {1'b0, dig};
    pp     = PP_W'(a_r) * PP_W'(factor);
    acc    = ACC_W'(hi_r) + ACC_W'(pp);
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a_r  <= mcand;
      b_r  <= mplier;
      hi_r <= '0;
    end else if (ctl.shift) begin
      hi_r <= acc[ACC_W-1:DIG_W];
      lo_r <= {acc[DIG_W-1:0], lo_r[FIELD_W-1:DIG_W]};
      b_r  <= b_r >> DIG_W;
    end
  end

  // drop the low fraction bits: arithmetic shift, i.e. round toward minus infinity
  assign prod = {hi_r[FIELD_W:0], lo_r[FIELD_W-1:FRAC_W]};

endmodule

`default_nettype wire

>>> hdl/rcpc_div.sv
// ----------------------------------------------------------------------------
// Radix-2 divider with overflow flag
// Forms floor(num * 2^16 / den) one quotient bit per cycle and flags a
// quotient that does not fit below 2^31.
// ----------------------------------------------------------------------------
`default_nettype none

module rcpc_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [rcpc_pkg::MAG_W-1:0]       num,
  input  logic [rcpc_pkg::MAG_W-1:0]       den,
  output rcpc_pkg::rcpc_div_sts_t          sts,
  output logic [rcpc_pkg::QUO_W-1:0]       quot
);

  import rcpc_pkg::*;

  localparam int CNT_W = $clog2(QUO_W);

  logic              busy_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [MAG_W-1:0]  rem_r;
  logic [MAG_W-1:0]  den_r;
  logic [QUO_W-1:0]  nq_r;
  logic              ovf_r;

  logic [MAG_W:0]    rs;
  logic [MAG_W+1:0]  diff;
  logic              ge;

  always_comb begin
    rs   = {rem_r, nq_r[QUO_W-1]};
    diff = {1'b0, rs} - {2'b00, den_r};
    ge   = !diff[MAG_W+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(QUO_W - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      // integer part of the partial remainder comes from the top numerator bits
      rem_r <= MAG_W'(num >> OVF_SH);
      nq_r  <= {num[OVF_SH-1:0], {FRAC_W{1'b0}}};
      ovf_r <= {{OVF_SH{1'b0}}, num} >= {den, {OVF_SH{1'b0}}};
    end else if (busy_r) begin
      rem_r <= ge ? diff[MAG_W-1:0] : rs[MAG_W-1:0];
      // numerator bits shift out the top, quotient bits shift in the bottom
      nq_r  <= {nq_r[QUO_W-2:0], ge};
    end
  end

  assign sts.done = busy_r && (cnt_r == CNT_W'(QUO_W - 1));
  assign sts.ovf  = ovf_r;
  assign quot     = nq_r;

endmodule

`default_nettype wire

>>> hdl/ray_convex_planes_clip.sv
// ----------------------------------------------------------------------------
// Ray convex clip
// Clips a ray against a convex set of planes, one plane per input transfer,
// and reports the entry/exit parameters on the plane marked last.
// ----------------------------------------------------------------------------
// One item is in flight at a time. Six digit-serial multipliers form the two
// dot products one 4-bit digit per cycle, followed by a sum and an evaluate
// state. A plane that needs the quotient -vN/vD then runs the radix-2
// divider; a parallel plane, or any plane after the set was rejected, skips
// it. The last plane of a set passes through an emit state that loads the
// result register, and waits there only if the previous result is still
// pending. A finished result sits in the output register while the next
// plane is accepted. The tolerance register is written through the cfg port
// while the block is idle; it resets to one LSB of Q16.16.
`default_nettype none
`include "ray_convex_planes_clip_assert.svh"

module ray_convex_planes_clip (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  rcpc_pkg::rcpc_in_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output rcpc_pkg::rcpc_out_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rcpc_pkg::EPS_W-1:0]    cfg_data
);

  import rcpc_pkg::*;

  localparam int NUM_MUL = 6;
  localparam int DCNT_W  = $clog2(DIGITS);
  localparam int HIT_W   = FIELD_W + 2;

  // control state
  rcpc_state_t              state_r, state_nxt;
  logic [DCNT_W-1:0]        dig_cnt_r, dig_cnt_nxt;
  logic signed [FIELD_W-1:0] near_r, near_nxt;
  logic signed [FIELD_W-1:0] far_r, far_nxt;
  logic                     rej_r, rej_nxt;
  logic [EPS_W-1:0]         eps_r;
  logic                     out_valid_r, out_valid_nxt;

  // payload
  logic signed [FIELD_W-1:0] pd_r, pd_nxt;
  logic                      last_r, last_nxt;
  logic signed [DOT_W-1:0]   vd_r, vd_nxt;
  logic signed [DOT_W-1:0]   vn_r, vn_nxt;
  logic [MAG_W-1:0]          div_num_r, div_num_nxt;
  logic [MAG_W-1:0]          div_den_r, div_den_nxt;
  logic                      neg_r, neg_nxt;
  logic                      vd_neg_r, vd_neg_nxt;
  logic                      take_r, take_nxt;
  rcpc_out_t                 out_r, out_nxt;

  logic                      in_xfer;
  rcpc_mul_ctl_t             mul_ctl;
  logic signed [FIELD_W-1:0] mul_a [NUM_MUL];
  logic signed [FIELD_W-1:0] mul_b [NUM_MUL];
  logic signed [PROD_W-1:0]  mul_p [NUM_MUL];
  logic                      div_start;
  rcpc_div_sts_t             div_sts;
  logic [QUO_W-1:0]          div_quot;

  assign in_xfer   = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    mul_a[0] = in_data.norm_x;  mul_b[0] = in_data.dir_x;
    mul_a[1] = in_data.norm_y;  mul_b[1] = in_data.dir_y;
    mul_a[2] = in_data.norm_z;  mul_b[2] = in_data.dir_z;
    mul_a[3] = in_data.norm_x;  mul_b[3] = in_data.org_x;
    mul_a[4] = in_data.norm_y;  mul_b[4] = in_data.org_y;
    mul_a[5] = in_data.norm_z;  mul_b[5] = in_data.org_z;
  end

  for (genvar k = 0; k < NUM_MUL; k++) begin : g_mul
    rcpc_dig_mul u_mul (
      .clk    (clk),
      .ctl    (mul_ctl),
      .mcand  (mul_a[k]),
      .mplier (mul_b[k]),
      .prod   (mul_p[k])
    );
  end

  rcpc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num_r),
    .den   (div_den_r),
    .sts   (div_sts),
    .quot  (div_quot)
  );

  always_comb begin
    logic signed [DOT_W-1:0]   eps_s;
    logic signed [DOT_W-1:0]   vd_abs;
    logic signed [DOT_W-1:0]   vn_abs;
    logic                      par;
    logic                      vn_pos;
    logic signed [FIELD_W-1:0] q_ext;
    logic signed [FIELD_W-1:0] t_val;
    logic signed [HIT_W-1:0]   near_x;
    logic signed [HIT_W-1:0]   far_x;

    state_nxt     = state_r;
    dig_cnt_nxt   = dig_cnt_r;
    near_nxt      = near_r;
    far_nxt       = far_r;
    rej_nxt       = rej_r;
    out_valid_nxt = out_valid_r && out_stall;
    pd_nxt        = pd_r;
    last_nxt      = last_r;
    vd_nxt        = vd_r;
    vn_nxt        = vn_r;
    div_num_nxt   = div_num_r;
    div_den_nxt   = div_den_r;
    neg_nxt       = neg_r;
    vd_neg_nxt    = vd_neg_r;
    take_nxt      = take_r;
    out_nxt       = out_r;
    mul_ctl       = '0;
    div_start     = 1'b0;

    eps_s  = {{(DOT_W-EPS_W){1'b0}}, eps_r};
    vd_abs = vd_r[DOT_W-1] ? -vd_r : vd_r;
    vn_abs = vn_r[DOT_W-1] ? -vn_r : vn_r;
    // parallel when vD is exactly zero or strictly inside +-eps
    par    = (vd_r == '0) || ((vd_r < eps_s) && (vd_r > -eps_s));
    vn_pos = !vn_r[DOT_W-1] && (vn_r != '0);

    q_ext = {1'b0, div_quot};
    if (div_sts.ovf) begin
      t_val = neg_r ? Q_MIN : Q_MAX;
    end else begin
      t_val = neg_r ? -q_ext : q_ext;
    end

    near_x = HIT_W'(near_r);
    far_x  = HIT_W'(far_r) + HIT_W'({1'b0, eps_r});

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          mul_ctl.load = 1'b1;
          pd_nxt       = in_data.plane_offset;
          last_nxt     = in_data.last_plane;
          dig_cnt_nxt  = '0;
          state_nxt    = ST_MUL;
        end
      end
      ST_MUL: begin
        mul_ctl.shift = 1'b1;
        mul_ctl.top   = (dig_cnt_r == DCNT_W'(DIGITS - 1));
        dig_cnt_nxt   = dig_cnt_r + DCNT_W'(1);
        if (dig_cnt_r == DCNT_W'(DIGITS - 1)) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        vd_nxt    = DOT_W'(mul_p[0]) + DOT_W'(mul_p[1]) + DOT_W'(mul_p[2]);
        vn_nxt    = DOT_W'(mul_p[3]) + DOT_W'(mul_p[4]) + DOT_W'(mul_p[5])
                    - DOT_W'(pd_r);
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        div_num_nxt = vn_abs[MAG_W-1:0];
        div_den_nxt = vd_abs[MAG_W-1:0];
        neg_nxt     = vn_pos ^ vd_r[DOT_W-1];
        vd_neg_nxt  = vd_r[DOT_W-1];
        take_nxt    = 1'b0;
        if (rej_r) begin
          state_nxt = ST_UPDATE;
        end else if (par) begin
          // origin clearly outside a parallel plane: the set misses
          if (vn_r < -eps_s) begin
            rej_nxt = 1'b1;
          end
          state_nxt = ST_UPDATE;
        end else begin
          take_nxt  = 1'b1;
          state_nxt = ST_DIV_START;
        end
      end
      ST_DIV_START: begin
        div_start = 1'b1;
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_sts.done) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (take_r) begin
          if (vd_neg_r) begin
            if (t_val < far_r) begin
              far_nxt = t_val;
            end
          end else begin
            if (t_val > near_r) begin
              near_nxt = t_val;
            end
          end
        end
        state_nxt = last_r ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_nxt.hit    = !rej_r && (near_x <= far_x);
          out_nxt.t_near = near_r;
          out_nxt.t_far  = far_r;
          out_valid_nxt  = 1'b1;
          near_nxt       = Q_MIN;
          far_nxt        = Q_MAX;
          rej_nxt        = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      dig_cnt_r   <= '0;
      near_r      <= Q_MIN;
      far_r       <= Q_MAX;
      rej_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dig_cnt_r   <= dig_cnt_nxt;
      near_r      <= near_nxt;
      far_r       <= far_nxt;
      rej_r       <= rej_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      eps_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    pd_r      <= pd_nxt;
    last_r    <= last_nxt;
    vd_r      <= vd_nxt;
    vn_r      <= vn_nxt;
    div_num_r <= div_num_nxt;
    div_den_r <= div_den_nxt;
    neg_r     <= neg_nxt;
    vd_neg_r  <= vd_neg_nxt;
    take_r    <= take_nxt;
    out_r     <= out_nxt;
  end

  `RCPC_ASSERT_NOW(a_div_done_in_wait, clk, rst_n, div_sts.done, state_r == ST_DIV_WAIT, "divider finished outside its wait state")
  `RCPC_ASSERT_NEXT(a_out_only_from_emit, clk, rst_n, (state_r != ST_EMIT) && !out_valid_r, !out_valid_r, "result raised without an emit")
  `RCPC_ASSERT_NEXT(a_reject_sticky, clk, rst_n, rej_r && (state_r != ST_EMIT), rej_r, "rejection dropped before the set ended")
  `RCPC_ASSERT_NEXT(a_bounds_cleared, clk, rst_n, (state_r == ST_EMIT) && (!out_valid_r || !out_stall), (near_r == Q_MIN) && (far_r == Q_MAX) && !rej_r, "bounds not cleared after a result")

endmodule

`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ray convex clip testbench
// Streams planes through the clipper under random input gaps and result
// stalls, predicts each set's entry/exit parameters and hit flag in fixed
// point, and compares every result transfer against the oldest prediction.
// ----------------------------------------------------------------------------

module testbench;
  import rcpc_pkg::*;

  localparam int     SETTLE_CYCLES = 64;
  localparam int     MAX_GAP       = 10;
  localparam longint RUN_LIMIT_NS  = 1_500_000;

  localparam logic signed [FIELD_W-1:0] ONE = 32'sh0001_0000;

  typedef enum int {SET_SHAPED, SET_PARALLEL, SET_NOISE, SET_EXTREME} set_kind_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  rcpc_in_t            in_data;
  logic                out_valid;
  logic                out_stall;
  rcpc_out_t           out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [EPS_W-1:0]    cfg_data;

  // predicted clipper state
  logic [EPS_W-1:0]    tol_q;
  longint              near_q;
  longint              far_q;
  bit                  set_rejected;
  rcpc_out_t           pending_clips[$];

  int                  error_count;
  int                  planes_sent;
  int                  out_hold;
  bit                  no_gaps;

  ray_convex_planes_clip dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // --------------------------------------------------------------------------
  // fixed-point predictor
  // --------------------------------------------------------------------------
  function automatic longint fix_mul(input longint a, input longint b);
    return (a * b) >>> FRAC_W;
  endfunction

  // quotient num/den in Q16.16, truncated toward zero, saturated to 32 bits
  function automatic longint fix_quot(input longint num, input longint den);
    logic [63:0] n_mag;
    logic [63:0] d_mag;
    logic [79:0] q_wide;
    bit          neg;
    neg    = (num < 0) != (den < 0);
    n_mag  = (num < 0) ? -num : num;
    d_mag  = (den < 0) ? -den : den;
    q_wide = {n_mag, 16'h0000} / {16'h0000, d_mag};
    if (q_wide >= 80'h8000_0000)
      return neg ? longint'(Q_MIN) : longint'(Q_MAX);
    return neg ? -longint'(q_wide[31:0]) : longint'(q_wide[31:0]);
  endfunction

  function automatic void clear_bounds();
    near_q       = longint'(Q_MIN);
    far_q        = longint'(Q_MAX);
    set_rejected = 1'b0;
  endfunction

  function automatic void clip_plane(input rcpc_in_t p);
    longint    v_d;
    longint    v_n;
    longint    t;
    longint    eps;
    rcpc_out_t res;
    eps = longint'(tol_q);
    if (!set_rejected) begin
      v_d = fix_mul(p.norm_x, p.dir_x) + fix_mul(p.norm_y, p.dir_y)
          + fix_mul(p.norm_z, p.dir_z);
      v_n = fix_mul(p.norm_x, p.org_x) + fix_mul(p.norm_y, p.org_y)
          + fix_mul(p.norm_z, p.org_z) - longint'(p.plane_offset);
      if (v_d == 0 || ((v_d < 0) ? -v_d : v_d) < eps) begin
        if (v_n < -eps)
          set_rejected = 1'b1;
      end else begin
        t = fix_quot(-v_n, v_d);
        if (v_d < 0) begin
          if (t < far_q)
            far_q = t;
        end else if (t > near_q) begin
          near_q = t;
        end
      end
    end
    if (p.last_plane) begin
      res.hit    = !set_rejected && (near_q <= far_q + eps);
      res.t_near = near_q[FIELD_W-1:0];
      res.t_far  = far_q[FIELD_W-1:0];
      pending_clips = {pending_clips, res};
      clear_bounds();
    end
  endfunction

  // --------------------------------------------------------------------------
  // item construction
  // --------------------------------------------------------------------------
  function automatic rcpc_in_t mk_plane(
    input logic signed [FIELD_W-1:0] dx, dy, dz, ox, oy, oz, nx, ny, nz, pd,
    input logic last
  );
    return {dx, dy, dz, ox, oy, oz, nx, ny, nz, pd, last};
  endfunction

  // ray along +x from the origin, so t equals the plane offset divided by nx
  function automatic rcpc_in_t x_plane(
    input logic signed [FIELD_W-1:0] nx, ny, pd,
    input logic last
  );
    return mk_plane(ONE, 0, 0, 0, 0, 0, nx, ny, 0, pd, last);
  endfunction

  function automatic logic signed [FIELD_W-1:0] rand_fix(input int bits);
    int span;
    span = 1 << bits;
    return int'($urandom_range(0, 2 * span - 1)) - span;
  endfunction

  function automatic logic signed [FIELD_W-1:0] pick_extreme();
    case ($urandom_range(0, 6))
      0:       return Q_MIN;
      1:       return Q_MAX;
      2:       return 0;
      3:       return 1;
      4:       return -1;
      5:       return ONE;
      default: return -ONE;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // channel drivers
  // --------------------------------------------------------------------------
  task automatic send_plane(input rcpc_in_t item);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    planes_sent++;
    clip_plane(item);
  endtask

  task automatic wait_results();
    if (pending_clips.size() != 0) begin
      in_valid <= 1'b0;
      while (pending_clips.size() != 0) @(posedge clk);
    end
  endtask

  task automatic write_epsilon(input logic [EPS_W-1:0] value);
    // a plane without a result may still be in the datapath
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    tol_q = value;
  endtask

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  // result receiver: random stall per transfer
  always @(posedge clk) begin : out_pacing
    int next_hold;
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_hold  <= 0;
    end else if (out_valid && !out_stall) begin
      next_hold = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
      out_hold  <= next_hold;
      out_stall <= (next_hold != 0);
    end else if (out_hold != 0) begin
      out_hold  <= out_hold - 1;
      out_stall <= (out_hold > 1);
    end
  end

  always @(posedge clk) begin : result_check
    rcpc_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_clips.size() == 0) begin
        report_mismatch($sformatf("unexpected result hit=%0b near=%h far=%h",
                                  out_data.hit, out_data.t_near, out_data.t_far));
      end else begin
        want = pending_clips.pop_front();
        if (out_data.hit !== want.hit)
          report_mismatch($sformatf("hit got %b want %b", out_data.hit, want.hit));
        if (out_data.t_near !== want.t_near)
          report_mismatch($sformatf("t_near got %h want %h",
                                    out_data.t_near, want.t_near));
        if (out_data.t_far !== want.t_far)
          report_mismatch($sformatf("t_far got %h want %h",
                                    out_data.t_far, want.t_far));
      end
    end
  end

  // --------------------------------------------------------------------------
  // random sets
  // --------------------------------------------------------------------------
  task automatic send_random_set();
    int                        kind_pick;
    int                        planes;
    int                        axis;
    set_kind_t                 kind;
    logic signed [FIELD_W-1:0] dir [3];
    logic signed [FIELD_W-1:0] org [3];
    logic signed [FIELD_W-1:0] nrm [3];
    logic signed [FIELD_W-1:0] pd;
    logic                      last;
    longint                    dot;
    kind_pick = $urandom_range(0, 99);
    if (kind_pick < 60)
      kind = SET_SHAPED;
    else if (kind_pick < 75)
      kind = SET_PARALLEL;
    else if (kind_pick < 90)
      kind = SET_NOISE;
    else
      kind = SET_EXTREME;
    planes = $urandom_range(1, 6);
    axis   = $urandom_range(0, 2);
    for (int k = 0; k < 3; k++) begin
      dir[k] = rand_fix(17);
      org[k] = rand_fix(18);
      if (kind == SET_PARALLEL && k != axis)
        dir[k] = 0;
    end
    for (int i = 0; i < planes; i++) begin
      last = (i == planes - 1);
      case (kind)
        SET_SHAPED, SET_PARALLEL: begin
          for (int k = 0; k < 3; k++)
            nrm[k] = rand_fix(17);
          if (kind == SET_PARALLEL && $urandom_range(0, 3) != 0)
            nrm[axis] = rand_fix(1);
          dot = fix_mul(nrm[0], org[0]) + fix_mul(nrm[1], org[1])
              + fix_mul(nrm[2], org[2]);
          // keep the origin inside most planes so the interval survives
          if ($urandom_range(0, 3) != 0)
            pd = FIELD_W'(dot - longint'($urandom_range(0, 1 << 18)));
          else
            pd = rand_fix(19);
        end
        SET_NOISE: begin
          for (int k = 0; k < 3; k++) begin
            dir[k] = $urandom();
            org[k] = $urandom();
            nrm[k] = $urandom();
          end
          pd   = $urandom();
          last = last | 1'($urandom_range(0, 1));
        end
        default: begin
          for (int k = 0; k < 3; k++) begin
            dir[k] = pick_extreme();
            org[k] = pick_extreme();
            nrm[k] = pick_extreme();
          end
          pd = pick_extreme();
        end
      endcase
      send_plane(mk_plane(dir[0], dir[1], dir[2], org[0], org[1], org[2],
                          nrm[0], nrm[1], nrm[2], pd, last));
    end
  endtask

  task automatic test_random_sets(input int count);
    int start;
    start = planes_sent;
    while (planes_sent - start < count) begin
      // now and then let the pipeline drain completely
      if ($urandom_range(0, 29) == 0)
        wait_results();
      send_random_set();
    end
  endtask

  // --------------------------------------------------------------------------
  // directed tests
  // --------------------------------------------------------------------------
  task automatic test_slab_hit();
    send_plane(x_plane(ONE, 0, -ONE, 1'b0));
    send_plane(x_plane(0, ONE, -ONE, 1'b0));
    send_plane(x_plane(-ONE, 0, -2 * ONE, 1'b1));
  endtask

  task automatic test_overlap_edge();
    logic signed [FIELD_W-1:0] b;
    b = 3 * ONE + 5;
    // near one tolerance past far still hits, two past misses
    send_plane(x_plane(ONE, 0, b + 1, 1'b0));
    send_plane(x_plane(-ONE, 0, -b, 1'b1));
    send_plane(x_plane(ONE, 0, b + 2, 1'b0));
    send_plane(x_plane(-ONE, 0, -b, 1'b1));
    // far side left unbounded, then both sides unbounded
    send_plane(x_plane(ONE, 0, -ONE, 1'b1));
    send_plane(x_plane(0, ONE, -ONE, 1'b1));
  endtask

  task automatic test_rejection();
    send_plane(x_plane(ONE, 0, -ONE, 1'b0));
    send_plane(x_plane(0, ONE, 5 * ONE, 1'b0));
    send_plane(x_plane(-ONE, 0, -2 * ONE, 1'b1));
    // rejected by the last plane itself
    send_plane(x_plane(ONE, 0, -ONE, 1'b0));
    send_plane(x_plane(0, ONE, 5 * ONE, 1'b1));
    // outside by exactly the tolerance stays accepted
    send_plane(x_plane(0, ONE, 1, 1'b1));
  endtask

  task automatic test_extremes();
    send_plane(mk_plane(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                        Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b1));
    send_plane(mk_plane(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                        Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b1));
    // tiny direction: quotient saturates both ways
    send_plane(mk_plane(2, 0, 0, 0, 0, 0, ONE, 0, 0, Q_MIN, 1'b0));
    send_plane(mk_plane(2, 0, 0, 0, 0, 0, ONE, 0, 0, Q_MAX, 1'b1));
    send_plane(mk_plane(-2, 0, 0, 0, 0, 0, ONE, 0, 0, Q_MAX, 1'b1));
    // negative products round toward minus infinity
    send_plane(mk_plane(-1, 0, 0, 3, 0, 0, 1, 0, 0, 0, 1'b1));
    send_plane(mk_plane(Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX,
                        Q_MIN, Q_MAX, Q_MIN, Q_MAX, 1'b1));
  endtask

  task automatic test_epsilon_zero();
    write_epsilon('0);
    // exact zero vD is still parallel, one LSB is not
    send_plane(x_plane(0, ONE, 0, 1'b1));
    send_plane(x_plane(1, 0, 0, 1'b1));
    send_plane(x_plane(0, ONE, 1, 1'b1));
    test_random_sets(250);
  endtask

  task automatic test_epsilon_max();
    write_epsilon({EPS_W{1'b1}});
    // half-unit vD counts as parallel, origin one unit outside then inside
    send_plane(x_plane(ONE / 2, 0, ONE, 1'b1));
    send_plane(x_plane(ONE / 2, 0, -ONE, 1'b1));
    test_random_sets(250);
  endtask

  task automatic test_back_to_back();
    write_epsilon(EPS_W'($urandom_range(1, 65534)));
    no_gaps = 1'b1;
    test_random_sets(150);
    no_gaps = 1'b0;
  endtask

  task automatic test_random_epsilon();
    for (int round = 0; round < 2; round++) begin
      write_epsilon(EPS_W'($urandom_range(0, 2000)));
      test_random_sets(200);
    end
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    tol_q       = EPS_RESET;
    error_count = 0;
    planes_sent = 0;
    no_gaps     = 1'b0;
    clear_bounds();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_slab_hit();
    test_overlap_edge();
    test_rejection();
    test_extremes();
    test_random_sets(300);
    test_epsilon_zero();
    test_epsilon_max();
    test_back_to_back();
    test_random_epsilon();

    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/rcpc_pkg.sv
hdl/rcpc_dig_mul.sv
hdl/rcpc_div.sv
hdl/ray_convex_planes_clip.sv
sim/testbench.sv
